### design/assert_macros.svh
// Assertion macros for the checker file of the date difference block.
// Depends on nothing; take it in by `include before the first use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define DD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication that starts at a transfer condition.
`define DD_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Check an implication whose consequent is judged in the following cycle.
`define DD_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### design/dd_pkg.sv
// Shared widths, calendar tables and controller command type for the
// date day difference block. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dd_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 22;
  // Day ordinal of the latest date, 16383-12-31, needs 23 bits
  localparam int unsigned ORD_W   = 23;
  // Quotient of a year by 100 stays below 164
  localparam int unsigned QUOT_W  = 8;
  localparam int unsigned QUART_W = YEAR_W - 2;
  localparam int unsigned PROD_W  = QUART_W + 13;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // floor(x / 25) = (x * 5243) >> 17 for every x below 4096
  localparam logic [12:0] RECIP_25    = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 17;

  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [6:0]  CENTURY       = 7'd100;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
  localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load;       // capture a new query
    logic sel_end;    // work on the end date rather than the start date
    logic stage1;     // register products and quotients of the selected year
    logic stage2;     // register the day ordinal and date check
    logic result_we;  // write the output register
  } dd_cmd_t;

  // Length of a month, zero for a month code that means nothing
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] n;
    case (m) inside
      MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
      MONTH_AUG, MONTH_OCT, MONTH_DEC:             n = 5'd31;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV:  n = 5'd30;
      MONTH_FEB:                                   n = leap ? 5'd29 : 5'd28;
      default:                                     n = '0;
    endcase
    return n;
  endfunction

  // Days in the months before month m of a common year
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    case (m)
      MONTH_JAN: n = 9'd0;
      MONTH_FEB: n = 9'd31;
      MONTH_MAR: n = 9'd59;
      MONTH_APR: n = 9'd90;
      MONTH_MAY: n = 9'd120;
      MONTH_JUN: n = 9'd151;
      MONTH_JUL: n = 9'd181;
      MONTH_AUG: n = 9'd212;
      MONTH_SEP: n = 9'd243;
      MONTH_OCT: n = 9'd273;
      MONTH_NOV: n = 9'd304;
      MONTH_DEC: n = 9'd334;
      default:   n = '0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

### design/dd_if.sv
// Valid/ready channel interfaces for the query and result transfers.
// Depends on dd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dd_in_if;
  logic                         valid;
  logic                         ready;
  logic [dd_pkg::YEAR_W-1:0]    start_year;
  logic [dd_pkg::MONTH_W-1:0]   start_month;
  logic [dd_pkg::DAY_W-1:0]     start_day;
  logic [dd_pkg::YEAR_W-1:0]    end_year;
  logic [dd_pkg::MONTH_W-1:0]   end_month;
  logic [dd_pkg::DAY_W-1:0]     end_day;
  logic                         include_end_day;

  modport source (output valid, start_year, start_month, start_day, end_year,
                  end_month, end_day, include_end_day, input ready);
  modport sink   (input valid, start_year, start_month, start_day, end_year,
                  end_month, end_day, include_end_day, output ready);
endinterface

interface dd_out_if;
  logic                         valid;
  logic                         ready;
  logic [dd_pkg::COUNT_W-1:0]   day_count;
  logic                         dates_valid;

  modport source (output valid, day_count, dates_valid, input ready);
  modport sink   (input valid, day_count, dates_valid, output ready);
endinterface

`default_nettype wire

### design/date_day_difference_unit.sv
// Top level of the Gregorian date day difference block.
// Depends on dd_pkg, dd_if, dd_ctrl and dd_datapath.
// Usage:
//   req_i carries one query: start date, end date and the include-end flag.
//   rsp_o carries one result per query: day_count and dates_valid.
//   Both are valid/ready channels; a transfer happens when valid and ready are
//   high at a rising edge of clk_i.
// Sequence:
//   req_i.ready is high only while the sequencer is idle. After a transfer the
//   shared ordinal unit works on the start date (S1, S2), then on the end date
//   (E1, E2), and FIN writes the difference into the output register; the
//   result appears on rsp_o once that register is written. The sequencer then
//   returns to idle and can take a new query, so queries do not overlap; this is
//   set by the two passes through the single ordinal unit.
// Stall:
//   A waiting result sits in the output register and does not stop the next
//   query from being taken; the sequencer holds its final step until the
//   output register drains.
// Reset:
//   rst_ni clears the sequencer to idle and drops rsp_o.valid; no stores need clearing.
`timescale 1ns / 1ps
`default_nettype none

module date_day_difference_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  dd_in_if.sink    req_i,
  dd_out_if.source rsp_o
);
  import dd_pkg::*;

  dd_cmd_t cmd;

  // Sequencer
  dd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // Datapath
  dd_datapath u_datapath (
    .clk_i             (clk_i),
    .cmd_i             (cmd),
    .start_year_i      (req_i.start_year),
    .start_month_i     (req_i.start_month),
    .start_day_i       (req_i.start_day),
    .end_year_i        (req_i.end_year),
    .end_month_i       (req_i.end_month),
    .end_day_i         (req_i.end_day),
    .include_end_day_i (req_i.include_end_day),
    .day_count_o       (rsp_o.day_count),
    .dates_valid_o     (rsp_o.dates_valid)
  );

endmodule

`default_nettype wire

### design/dd_ctrl.sv
// Sequencer for the date difference block: steps the shared ordinal unit
// over both dates and owns the output valid flag. Depends on dd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dd_pkg::dd_cmd_t cmd_o
);
  import dd_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_S1   = 6'b000010,
    ST_S2   = 6'b000100,
    ST_E1   = 6'b001000,
    ST_E2   = 6'b010000,
    ST_FIN  = 6'b100000
  } dd_state_e;

  dd_state_e state_q, state_d;
  logic      out_valid_q, out_valid_d;
  logic      out_free;

  // The output register is free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) state_d = ST_S1;
      end
      ST_S1: begin
        cmd_o.stage1 = 1'b1;
        state_d      = ST_S2;
      end
      ST_S2: begin
        cmd_o.stage2 = 1'b1;
        state_d      = ST_E1;
      end
      ST_E1: begin
        cmd_o.sel_end = 1'b1;
        cmd_o.stage1  = 1'b1;
        state_d       = ST_E2;
      end
      ST_E2: begin
        cmd_o.sel_end = 1'b1;
        cmd_o.stage2  = 1'b1;
        state_d       = ST_FIN;
      end
      ST_FIN: begin
        // Hold the finished count until the output register is free
        cmd_o.result_we = out_free;
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.result_we;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### design/dd_datapath.sv
// Datapath of the date difference block: query registers, a two-step day
// ordinal unit shared by both dates, and the output register. Depends on dd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dd_datapath (
  input  logic                         clk_i,
  input  dd_pkg::dd_cmd_t              cmd_i,
  input  logic [dd_pkg::YEAR_W-1:0]    start_year_i,
  input  logic [dd_pkg::MONTH_W-1:0]   start_month_i,
  input  logic [dd_pkg::DAY_W-1:0]     start_day_i,
  input  logic [dd_pkg::YEAR_W-1:0]    end_year_i,
  input  logic [dd_pkg::MONTH_W-1:0]   end_month_i,
  input  logic [dd_pkg::DAY_W-1:0]     end_day_i,
  input  logic                         include_end_day_i,
  output logic [dd_pkg::COUNT_W-1:0]   day_count_o,
  output logic                         dates_valid_o
);
  import dd_pkg::*;

  // Query registers
  logic [YEAR_W-1:0]  sy_q, ey_q;
  logic [MONTH_W-1:0] sm_q, em_q;
  logic [DAY_W-1:0]   sd_q, ed_q;
  logic               inc_q;

  // Stage one of the ordinal unit
  logic [YEAR_W-1:0]  y_sel, p_sel;
  logic [MONTH_W-1:0] m_sel;
  logic [DAY_W-1:0]   d_sel;
  logic [PROD_W-1:0]  prod_y, prod_p;
  logic [YEAR_W-1:0]  y_q;
  logic [MONTH_W-1:0] m_q;
  logic [DAY_W-1:0]   d_q;
  logic [ORD_W-1:0]   y365_q;
  logic [QUART_W-1:0] p4_q;
  logic [QUOT_W-1:0]  p100_q, y100_q;

  // Stage two of the ordinal unit
  logic [YEAR_W:0]    y100x;
  logic               cent, leap, leap_adj, date_ok;
  logic [QUART_W:0]   leaps;
  logic [DAY_W-1:0]   mdays;
  logic [ORD_W-1:0]   ord;
  logic [ORD_W-1:0]   ord_a_q, ord_b_q;
  logic               valid_q;

  // Final difference
  logic [ORD_W-1:0]   diff;
  logic [ORD_W:0]     count_raw;
  logic [COUNT_W-1:0] count_sat;
  logic [COUNT_W-1:0] count_q;
  logic               dvalid_q;

  // Capture the query on its transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sy_q  <= start_year_i;
      sm_q  <= start_month_i;
      sd_q  <= start_day_i;
      ey_q  <= end_year_i;
      em_q  <= end_month_i;
      ed_q  <= end_day_i;
      inc_q <= include_end_day_i;
    end
  end

  // Select the date and divide year and year-1 by 100 as (x/4)/25
  assign y_sel  = cmd_i.sel_end ? ey_q : sy_q;
  assign m_sel  = cmd_i.sel_end ? em_q : sm_q;
  assign d_sel  = cmd_i.sel_end ? ed_q : sd_q;
  assign p_sel  = y_sel - YEAR_W'(1);
  assign prod_y = PROD_W'(y_sel[YEAR_W-1:2]) * PROD_W'(RECIP_25);
  assign prod_p = PROD_W'(p_sel[YEAR_W-1:2]) * PROD_W'(RECIP_25);

  always_ff @(posedge clk_i) begin
    if (cmd_i.stage1) begin
      y_q    <= y_sel;
      m_q    <= m_sel;
      d_q    <= d_sel;
      y365_q <= ORD_W'(y_sel) * ORD_W'(DAYS_PER_YEAR);
      p4_q   <= p_sel[YEAR_W-1:2];
      p100_q <= prod_p[RECIP_SHIFT +: QUOT_W];
      y100_q <= prod_y[RECIP_SHIFT +: QUOT_W];
    end
  end

  // Leap rule, month length and ordinal from the start of year 0
  assign y100x    = (YEAR_W+1)'(y100_q) * (YEAR_W+1)'(CENTURY);
  assign cent     = (y100x == {1'b0, y_q});
  assign leap     = ((y_q[1:0] == 2'b00) && !cent) || (cent && (y100_q[1:0] == 2'b00));
  assign leaps    = (y_q == '0) ? '0
                  : (QUART_W+1)'(1) + (QUART_W+1)'(p4_q) - (QUART_W+1)'(p100_q)
                    + (QUART_W+1)'(p100_q[QUOT_W-1:2]);
  assign mdays    = month_days(m_q, leap);
  assign date_ok  = (mdays != '0) && (d_q != '0) && (d_q <= mdays);
  assign leap_adj = leap && (m_q > MONTH_FEB);
  assign ord      = y365_q + ORD_W'(leaps) + ORD_W'(days_before(m_q)) + ORD_W'(d_q)
                  + ORD_W'(leap_adj);

  always_ff @(posedge clk_i) begin
    if (cmd_i.stage2) begin
      if (cmd_i.sel_end) begin
        ord_b_q <= ord;
        valid_q <= valid_q && date_ok;
      end else begin
        ord_a_q <= ord;
        valid_q <= date_ok;
      end
    end
  end

  // Difference clamped at zero, end-day increment and saturation
  assign diff      = (ord_a_q < ord_b_q) ? (ord_b_q - ord_a_q) : '0;
  assign count_raw = (ORD_W+1)'(diff) + (ORD_W+1)'(inc_q);
  assign count_sat = (count_raw > (ORD_W+1)'(COUNT_MAX)) ? COUNT_MAX
                                                         : count_raw[COUNT_W-1:0];

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.result_we) begin
      count_q  <= valid_q ? count_sat : '0;
      dvalid_q <= valid_q;
    end
  end

  assign day_count_o   = count_q;
  assign dates_valid_o = dvalid_q;

endmodule

`default_nettype wire

### design/dd_checker.sv
// Port-level checks for the date day difference block, bound to its top level.
// Depends on assert_macros.svh and dd_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dd_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [dd_pkg::COUNT_W-1:0] day_count_i,
  input  logic                       dates_valid_i
);
  import dd_pkg::*;

  // A waiting result stays offered
  `DD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")

  // A waiting result keeps its count
  `DD_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(day_count_i), "stalled count changed")

  // An invalid date pair always reports a zero count
  `DD_ASSERT_IMP(a_invalid_zero, clk_i, rst_ni, out_valid_i && !dates_valid_i, day_count_i == '0, "invalid dates with non-zero count")

  // The block is busy in the cycle after a query transfer
  `DD_ASSERT_NXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "query taken while busy")

endmodule

bind date_day_difference_unit dd_checker u_dd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .day_count_i   (rsp_o.day_count),
  .dates_valid_i (rsp_o.dates_valid)
);

`default_nettype wire
